FILE: src/bpfq_pkg.sv
package bpfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_PACKET  = 64;
  localparam int NSLOT       = QUEUE_DEPTH + 1;
  localparam int SLOT_W      = $clog2(NSLOT);
  localparam int IDX_W       = $clog2(MAX_PACKET);
  localparam int LEN_W       = $clog2(MAX_PACKET + 1);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = NSLOT * MAX_PACKET;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FIXED_MODE     = 3'd0;
  localparam cfg_idx_t REG_DELIMITER_BYTE = 3'd1;
  localparam cfg_idx_t REG_PACKET_LENGTH  = 3'd2;
  localparam cfg_idx_t REG_QUEUE_LIMIT    = 3'd3;

  localparam logic       RST_FIXED_MODE     = 1'b0;
  localparam logic [7:0] RST_DELIMITER_BYTE = 8'd10;
  localparam logic [6:0] RST_PACKET_LENGTH  = 7'd9;
  localparam logic [4:0] RST_QUEUE_LIMIT    = 5'd16;

  localparam logic OP_RX  = 1'b0;
  localparam logic OP_POP = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t STAT_BYTE     = 2'd0;
  localparam status_t STAT_EMPTY    = 2'd1;
  localparam status_t STAT_ZERO_LEN = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             last;
    status_t          status;
    logic             truncated;
    logic [CNT_W-1:0] packets_waiting;
  } result_t;

  typedef struct packed {
    logic       fixed_mode;
    logic [7:0] delimiter_byte;
    logic [6:0] packet_length;
    logic [4:0] queue_limit;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    logic       pop;
    logic       is_delim;
    logic [7:0] data;
  } cmd_t;

endpackage

FILE: src/bpfq_front.sv
module bpfq_front import bpfq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  item_t      item_i,
  input  logic [7:0] delimiter_i,
  output logic       busy_o,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_take_i
);

  cmd_t                  cmdq_mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  full, push, pop;
  cmd_t                  new_cmd;

  function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] p);
    ptr_inc = (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + CMDQ_PTR_W'(1);
  endfunction

  assign full        = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign busy_o      = full;
  assign push        = start_i && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_take_i && cmd_valid_o;
  assign cmd_o       = cmdq_mem[rd_ptr_q];

  // delimiter compare done here so the back end only sees a flag
  always_comb begin
    new_cmd.pop      = (item_i.operation == OP_POP);
    new_cmd.is_delim = (item_i.rx_byte == delimiter_i);
    new_cmd.data     = item_i.rx_byte;
  end

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CMDQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmdq_mem[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

FILE: src/bpfq_back.sv
module bpfq_back import bpfq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_take_o,
  output logic    result_valid_o,
  output result_t result_o
);

  typedef enum logic {ST_IDLE, ST_STREAM} state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [SLOT_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [LEN_W-1:0]  asm_len_q, asm_len_d;
  logic              asm_tr_q, asm_tr_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [LEN_W-1:0]  rd_len_q, rd_len_d;
  logic              out_valid_q, out_valid_d;
  logic              out_mem_q, out_mem_d;
  logic              out_last_q, out_last_d;
  status_t           out_status_q, out_status_d;
  logic              out_tr_q, out_tr_d;
  logic [CNT_W-1:0]  out_wait_q, out_wait_d;

  logic [LEN_W-1:0]  slot_len_q [NSLOT];
  logic              slot_tr_q  [NSLOT];
  logic              slot_we;

  logic [7:0]        store_mem [STORE_DEPTH];
  logic [7:0]        rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;

  logic [CNT_W-1:0]  lim;
  logic [LEN_W-1:0]  nlen;
  logic              do_close, do_store, drop;
  logic [CNT_W-1:0]  drop_cnt;
  logic [SLOT_W:0]   head_sum;
  logic [SLOT_W-1:0] head_drop, tail_next, tail_eff;
  logic [LEN_W-1:0]  len_eff;
  logic              tr_eff;
  logic [LEN_W-1:0]  pop_len;
  logic              stream_last;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(NSLOT - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [IDX_W-1:0]  i);
    store_addr = ADDR_W'(s) * ADDR_W'(MAX_PACKET) + ADDR_W'(i);
  endfunction

  // clamp the configured limits into their working ranges
  always_comb begin
    if (cfg_i.queue_limit == '0) begin
      lim = CNT_W'(1);
    end else if (CNT_W'(cfg_i.queue_limit) > CNT_W'(QUEUE_DEPTH)) begin
      lim = CNT_W'(QUEUE_DEPTH);
    end else begin
      lim = CNT_W'(cfg_i.queue_limit);
    end
    if (cfg_i.packet_length == '0) begin
      nlen = LEN_W'(1);
    end else if (LEN_W'(cfg_i.packet_length) > LEN_W'(MAX_PACKET)) begin
      nlen = LEN_W'(MAX_PACKET);
    end else begin
      nlen = LEN_W'(cfg_i.packet_length);
    end
  end

  // framing decision for a received byte
  always_comb begin
    do_close  = cfg_i.fixed_mode ? (asm_len_q >= nlen) : cmd_i.is_delim;
    do_store  = cfg_i.fixed_mode || !cmd_i.is_delim;
    drop      = (count_q >= lim);
    // drop oldest packets so that the new one fits
    drop_cnt  = count_q - lim + CNT_W'(1);
    head_sum  = (SLOT_W+1)'(head_q) + (SLOT_W+1)'(drop_cnt);
    head_drop = (head_sum >= (SLOT_W+1)'(NSLOT)) ? SLOT_W'(head_sum - (SLOT_W+1)'(NSLOT))
                                                 : SLOT_W'(head_sum);
    tail_next = slot_inc(tail_q);
    tail_eff  = do_close ? tail_next : tail_q;
    len_eff   = do_close ? '0 : asm_len_q;
    tr_eff    = do_close ? 1'b0 : asm_tr_q;
    pop_len   = slot_len_q[head_q];
    stream_last = ((LEN_W'(rd_idx_q) + LEN_W'(1)) == rd_len_q);
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    asm_len_d    = asm_len_q;
    asm_tr_d     = asm_tr_q;
    rd_slot_d    = rd_slot_q;
    rd_idx_d     = rd_idx_q;
    rd_len_d     = rd_len_q;
    out_valid_d  = 1'b0;
    out_mem_d    = 1'b0;
    out_last_d   = 1'b0;
    out_status_d = STAT_BYTE;
    out_tr_d     = 1'b0;
    out_wait_d   = '0;
    cmd_take_o   = 1'b0;
    slot_we      = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = store_addr(tail_eff, len_eff[IDX_W-1:0]);
    mem_re       = 1'b0;
    mem_raddr    = store_addr(head_q, '0);

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          if (!cmd_i.pop) begin
            if (do_close) begin
              slot_we   = 1'b1;
              tail_d    = tail_next;
              head_d    = drop ? head_drop : head_q;
              count_d   = drop ? lim : count_q + CNT_W'(1);
              asm_len_d = '0;
              asm_tr_d  = 1'b0;
            end
            if (do_store) begin
              if (len_eff < LEN_W'(MAX_PACKET)) begin
                mem_we    = 1'b1;
                asm_len_d = len_eff + LEN_W'(1);
                asm_tr_d  = tr_eff;
              end else begin
                asm_tr_d  = 1'b1;
              end
            end
          end else if (count_q == '0) begin
            out_valid_d  = 1'b1;
            out_last_d   = 1'b1;
            out_status_d = STAT_EMPTY;
          end else begin
            head_d      = slot_inc(head_q);
            count_d     = count_q - CNT_W'(1);
            out_valid_d = 1'b1;
            out_tr_d    = slot_tr_q[head_q];
            out_wait_d  = count_q - CNT_W'(1);
            if (pop_len == '0) begin
              out_last_d   = 1'b1;
              out_status_d = STAT_ZERO_LEN;
            end else begin
              // first byte read issued right away
              mem_re     = 1'b1;
              out_mem_d  = 1'b1;
              out_last_d = (pop_len == LEN_W'(1));
              if (pop_len != LEN_W'(1)) begin
                state_d   = ST_STREAM;
                rd_slot_d = head_q;
                rd_idx_d  = IDX_W'(1);
                rd_len_d  = pop_len;
              end
            end
          end
        end
      end
      ST_STREAM: begin
        mem_re      = 1'b1;
        mem_raddr   = store_addr(rd_slot_q, rd_idx_q);
        out_valid_d = 1'b1;
        out_mem_d   = 1'b1;
        out_last_d  = stream_last;
        out_tr_d    = out_tr_q;
        out_wait_d  = count_q;
        rd_idx_d    = rd_idx_q + IDX_W'(1);
        if (stream_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      asm_len_q    <= '0;
      asm_tr_q     <= 1'b0;
      rd_slot_q    <= '0;
      rd_idx_q     <= '0;
      rd_len_q     <= '0;
      out_valid_q  <= 1'b0;
      out_mem_q    <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= STAT_BYTE;
      out_tr_q     <= 1'b0;
      out_wait_q   <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      asm_len_q    <= asm_len_d;
      asm_tr_q     <= asm_tr_d;
      rd_slot_q    <= rd_slot_d;
      rd_idx_q     <= rd_idx_d;
      rd_len_q     <= rd_len_d;
      out_valid_q  <= out_valid_d;
      out_mem_q    <= out_mem_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
      out_tr_q     <= out_tr_d;
      out_wait_q   <= out_wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_len_q[tail_q] <= asm_len_q;
      slot_tr_q[tail_q]  <= asm_tr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= cmd_i.data;
    end
    if (mem_re) begin
      rdata_q <= store_mem[mem_raddr];
    end
  end

  assign result_valid_o           = out_valid_q;
  assign result_o.data_byte       = out_mem_q ? rdata_q : 8'd0;
  assign result_o.last            = out_last_q;
  assign result_o.status          = out_status_q;
  assign result_o.truncated       = out_tr_q;
  assign result_o.packets_waiting = out_wait_q;

endmodule

FILE: src/byte_packet_framer_queue_unit.sv
// channel  | ports                                  | handshake
// ---------+----------------------------------------+------------------------------
// item in  | start_i, item_i, busy_o                | taken when start_i && !busy_o
// result   | result_valid_o, result_o               | one-cycle strobe, no backpressure
// config   | cfg_we_i, cfg_idx_i, cfg_data_i        | written when cfg_we_i is high
//
// Items queue in a 4-entry command queue ahead of the back unit, and busy_o rises only
// when it is full.
// A pop streams a packet of L bytes one byte per cycle through the single read port of
// the packet store; the first result shows in the cycle after the pop is executed, and
// the rest follow back to back.
// Reset is asynchronous; the packet store and slot tables need no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module byte_packet_framer_queue_unit import bpfq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  item_t                 item_i,
  output logic                  busy_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  result_valid_o,
  output result_t               result_o
);

  cfg_t cfg_q, cfg_d;
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIXED_MODE:     cfg_d.fixed_mode     = cfg_data_i[0];
        REG_DELIMITER_BYTE: cfg_d.delimiter_byte = cfg_data_i[7:0];
        REG_PACKET_LENGTH:  cfg_d.packet_length  = cfg_data_i[6:0];
        REG_QUEUE_LIMIT:    cfg_d.queue_limit    = cfg_data_i[4:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fixed_mode     <= RST_FIXED_MODE;
      cfg_q.delimiter_byte <= RST_DELIMITER_BYTE;
      cfg_q.packet_length  <= RST_PACKET_LENGTH;
      cfg_q.queue_limit    <= RST_QUEUE_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bpfq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .delimiter_i (cfg_q.delimiter_byte),
    .busy_o      (busy_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  bpfq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_take_o     (cmd_take),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

FILE: src/bpfq_checker.sv
module bpfq_port_checks import bpfq_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    result_valid_o,
  input result_t result_o
);

  // empty-queue report carries nothing else
  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status == STAT_EMPTY |->
      result_o.last && result_o.packets_waiting == '0 &&
      !result_o.truncated && result_o.data_byte == 8'd0)
    else $error("empty-queue result with non-zero fields");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != STAT_BYTE |-> result_o.last)
    else $error("status-only result without last");

  // a packet streams out with no gaps
  a_stream_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status == STAT_BYTE && !result_o.last |=>
      result_valid_o && result_o.status == STAT_BYTE)
    else $error("gap inside a packet stream");

  a_stream_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=>
      $stable(result_o.packets_waiting) && $stable(result_o.truncated))
    else $error("per-packet fields changed mid-stream");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      result_o.packets_waiting <= CNT_W'(QUEUE_DEPTH) &&
      (result_o.status == STAT_BYTE || result_o.status == STAT_EMPTY ||
       result_o.status == STAT_ZERO_LEN))
    else $error("result field out of range");

endmodule

bind byte_packet_framer_queue_unit bpfq_port_checks u_bpfq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

FILE: bench/bpfq_checker.sv
module bpfq_checker import bpfq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  item_t                 item_i,
  input  logic                  busy_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  result_valid_o,
  input  result_t               result_o,
  output int                    pending_o,
  output int                    errors_o
);

  // mirror of the framer: slot ring, per-slot length and truncation flag
  logic [7:0]  frame_bytes [NSLOT][MAX_PACKET];
  int unsigned frame_len   [NSLOT];
  bit          frame_trunc [NSLOT];
  int unsigned head_idx, tail_idx, held_count, build_len;
  bit          build_trunc;
  cfg_t        regs;
  result_t     expected_results [$];
  int          mismatches;

  function automatic void add_expected(result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void close_frame();
    int unsigned cap;
    cap = 32'(regs.queue_limit);
    if (cap < 1) cap = 1;
    if (cap > QUEUE_DEPTH) cap = QUEUE_DEPTH;
    while (held_count >= cap && held_count > 0) begin
      head_idx = (head_idx + 1) % NSLOT;
      held_count--;
    end
    frame_len[tail_idx]   = build_len;
    frame_trunc[tail_idx] = build_trunc;
    tail_idx    = (tail_idx + 1) % NSLOT;
    held_count++;
    build_len   = 0;
    build_trunc = 1'b0;
  endfunction

  function automatic void keep_byte(logic [7:0] b);
    if (build_len < MAX_PACKET) begin
      frame_bytes[tail_idx][build_len] = b;
      build_len++;
    end else begin
      build_trunc = 1'b1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t     r;
    result_t     want;
    int unsigned s, len, eff;
    bit          tr;
    if (!rst_ni) begin
      regs        = '{RST_FIXED_MODE, RST_DELIMITER_BYTE, RST_PACKET_LENGTH, RST_QUEUE_LIMIT};
      head_idx    = 0;
      tail_idx    = 0;
      held_count  = 0;
      build_len   = 0;
      build_trunc = 1'b0;
      mismatches  = 0;
      expected_results.delete();
      pending_o  <= 0;
      errors_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FIXED_MODE:     regs.fixed_mode     = cfg_data_i[0];
          REG_DELIMITER_BYTE: regs.delimiter_byte = cfg_data_i;
          REG_PACKET_LENGTH:  regs.packet_length  = cfg_data_i[6:0];
          REG_QUEUE_LIMIT:    regs.queue_limit    = cfg_data_i[4:0];
          default: ;
        endcase
      end

      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %p", result_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (result_o.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0d, got %0d", want.data_byte, result_o.data_byte);
            mismatches++;
          end
          if (result_o.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, result_o.last);
            mismatches++;
          end
          if (result_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_o.status);
            mismatches++;
          end
          if (result_o.truncated !== want.truncated) begin
            $error("truncated: expected %0d, got %0d", want.truncated, result_o.truncated);
            mismatches++;
          end
          if (result_o.packets_waiting !== want.packets_waiting) begin
            $error("packets_waiting: expected %0d, got %0d",
                   want.packets_waiting, result_o.packets_waiting);
            mismatches++;
          end
        end
      end

      if (start_i && !busy_o) begin
        if (item_i.operation == OP_RX) begin
          if (regs.fixed_mode) begin
            eff = 32'(regs.packet_length);
            if (eff < 1) eff = 1;
            if (eff > MAX_PACKET) eff = MAX_PACKET;
            // overlong partial packet from delimiter mode closes here too
            if (build_len >= eff) close_frame();
            keep_byte(item_i.rx_byte);
          end else if (item_i.rx_byte == regs.delimiter_byte) begin
            close_frame();
          end else begin
            keep_byte(item_i.rx_byte);
          end
        end else if (held_count == 0) begin
          r        = '0;
          r.last   = 1'b1;
          r.status = STAT_EMPTY;
          add_expected(r);
        end else begin
          s   = head_idx;
          len = frame_len[s];
          tr  = frame_trunc[s];
          head_idx = (head_idx + 1) % NSLOT;
          held_count--;
          r                 = '0;
          r.truncated       = tr;
          r.packets_waiting = CNT_W'(held_count);
          if (len == 0) begin
            r.last   = 1'b1;
            r.status = STAT_ZERO_LEN;
            add_expected(r);
          end else begin
            for (int unsigned k = 0; k < len; k++) begin
              r.data_byte = frame_bytes[s][k];
              r.last      = (k + 1 == len);
              r.status    = STAT_BYTE;
              add_expected(r);
            end
          end
        end
      end

      pending_o <= expected_results.size();
      errors_o  <= mismatches;
    end
  end

endmodule

FILE: bench/tb_byte_packet_framer_queue_unit.sv
module tb_byte_packet_framer_queue_unit;
  import bpfq_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 270;

  localparam logic [7:0] LEN_EDGES [5] = '{8'd0, 8'd1, 8'd64, 8'd127, 8'd200};
  localparam logic [7:0] LIM_EDGES [6] = '{8'd0, 8'd1, 8'd16, 8'd17, 8'd31, 8'd255};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  item_t                 item_i;
  logic                  busy_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  result_valid_o;
  result_t               result_o;

  int         pending;
  int         fail_count;
  int         cycles = 0;
  int         items_sent = 0;
  bit         gaps_on = 1'b1;
  logic       cur_mode;
  logic [7:0] cur_delim;
  int         cur_len_eff;

  byte_packet_framer_queue_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  bpfq_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .pending_o      (pending),
    .errors_o       (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // start_i stays high after acceptance; the next call lowers it only when idling
  task automatic send_item(input logic op, input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 37) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= '{operation: op, rx_byte: b};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // trailing byte items may still sit in the command queue
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic mode, input logic [7:0] delim,
                           input logic [7:0] plen, input logic [7:0] qlim);
    write_reg(CFG_IDX_W'(REG_QUEUE_LIMIT + 1 + $urandom_range(3)), 8'($urandom));
    write_reg(REG_FIXED_MODE, {7'($urandom), mode});
    write_reg(REG_DELIMITER_BYTE, delim);
    write_reg(REG_PACKET_LENGTH, plen);
    write_reg(REG_QUEUE_LIMIT, qlim);
    cfg_we_i    <= 1'b0;
    cur_mode     = mode;
    cur_delim    = delim;
    cur_len_eff  = int'(plen[6:0]);
    if (cur_len_eff < 1) cur_len_eff = 1;
    if (cur_len_eff > MAX_PACKET) cur_len_eff = MAX_PACKET;
  endtask

  // one well-formed packet; in delimiter mode long_one sends 62 to 70 bytes
  task automatic send_frame(input bit long_one);
    int         n;
    int         r;
    logic [7:0] b;
    if (cur_mode) begin
      n = (cur_len_eff <= 16 || $urandom_range(3) == 0) ? cur_len_eff : $urandom_range(16, 1);
      repeat (n) send_item(OP_RX, 8'($urandom));
    end else begin
      r = $urandom_range(99);
      if (long_one || r < 6) n = $urandom_range(70, 62);
      else if (r < 18)       n = 0;
      else                   n = $urandom_range(8, 1);
      repeat (n) begin
        do b = 8'($urandom); while (b == cur_delim);
        send_item(OP_RX, b);
      end
      send_item(OP_RX, cur_delim);
    end
  endtask

  initial begin
    int         rand_from;
    int         budget;
    int         pick;
    int         phase;
    logic [7:0] delim;
    logic [7:0] plen;
    logic [7:0] qlim;

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    cur_mode     = RST_FIXED_MODE;
    cur_delim    = RST_DELIMITER_BYTE;
    cur_len_eff  = int'(RST_PACKET_LENGTH);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, empty packet, byte extremes, mode switch mid-packet
    send_item(OP_POP, 8'hFF);
    send_item(OP_RX, cur_delim);
    send_item(OP_POP, 8'h00);
    send_item(OP_RX, 8'h00);
    send_item(OP_RX, 8'hFF);
    send_item(OP_RX, 8'hA5);
    send_item(OP_RX, cur_delim);
    send_item(OP_POP, 8'h5A);
    repeat (12) send_item(OP_RX, 8'($urandom_range(9)));
    wait_idle();
    configure(1'b1, RST_DELIMITER_BYTE, 8'd3, 8'(RST_QUEUE_LIMIT));
    send_item(OP_RX, 8'h5A);
    send_item(OP_POP, 8'($urandom));
    send_item(OP_POP, 8'($urandom));

    rand_from = items_sent;
    phase = 0;
    while (items_sent < rand_from + RANDOM_ITEMS) begin
      wait_idle();
      gaps_on = (phase != 2);
      if (phase == 0) begin
        configure(1'b0, 8'h00, 8'd1, 8'd1);
      end else if (phase == 1) begin
        configure(1'b1, 8'hFF, 8'd64, 8'd16);
      end else if (phase == 3) begin
        configure(1'b0, 8'hFF, 8'd0, 8'd0);
      end else begin
        pick  = $urandom_range(3);
        delim = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
                (pick == 2) ? RST_DELIMITER_BYTE : 8'($urandom);
        plen  = ($urandom_range(3) == 0) ? LEN_EDGES[$urandom_range(4)]
                                         : 8'($urandom_range(10, 1));
        qlim  = ($urandom_range(3) == 0) ? LIM_EDGES[$urandom_range(5)]
                                         : 8'($urandom_range(16, 1));
        configure(1'($urandom_range(1)), delim, plen, qlim);
      end
      if (phase == 3) send_frame(1'b1);
      budget = items_sent + $urandom_range(40, 20);
      while (items_sent < budget) begin
        pick = $urandom_range(99);
        if (pick < 30)      send_item(OP_POP, 8'($urandom));
        else if (pick < 40) send_item(OP_RX, 8'($urandom));
        else                send_frame(1'b0);
      end
      phase++;
    end
    // drain whatever is still queued
    gaps_on = 1'b1;
    repeat (QUEUE_DEPTH + 1) send_item(OP_POP, 8'($urandom));
    wait_idle();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
